// ===== rtl/tsa_pkg.sv =====
// ----------------------------------------------------------------------------
// tsa_pkg
// Types, codes and the update schedule shared by the truss stiffness
// assembler modules.
// ----------------------------------------------------------------------------
package tsa_pkg;

	// Item kinds.
	localparam logic [1:0] KIND_ADD   = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	// Result status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_ZERO = 2'd1;
	localparam logic [1:0] STAT_SAT  = 2'd2;

	// Field widths.
	localparam int DOF_W   = 7;
	localparam int TERM_W  = 48;
	localparam int ENTRY_W = 40;

	// Saturation limits of a stored entry.
	localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = 40'sh7F_FFFF_FFFF;
	localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = 40'sh80_0000_0000;

	// Which element term an update uses.
	localparam logic [1:0] TS_CC = 2'd0;
	localparam logic [1:0] TS_CS = 2'd1;
	localparam logic [1:0] TS_SS = 2'd2;

	// One step of the element matrix scatter: row dof, column dof, term, sign.
	typedef struct packed {
		logic [1:0] rsel;
		logic [1:0] csel;
		logic [1:0] tsel;
		logic       neg;
	} upd_t;

	// A classified item on its way from the front to the back.
	typedef struct packed {
		logic [1:0]        kind;
		logic              zero_len;
		logic              cs_neg;
		logic [DOF_W-1:0]  dof1;
		logic [DOF_W-1:0]  dof2;
		logic [DOF_W-1:0]  dof3;
		logic [DOF_W-1:0]  dof4;
		logic [DOF_W-1:0]  read_row;
		logic [DOF_W-1:0]  read_col;
		logic [TERM_W-1:0] tcc;
		logic [TERM_W-1:0] tcs;
		logic [TERM_W-1:0] tss;
	} job_t;

	// Fixed order of the sixteen updates of one strut.
	function automatic upd_t upd_entry(input logic [3:0] idx);
		upd_t u;
		case (idx)
			4'd0:    u = '{2'd0, 2'd0, TS_CC, 1'b0};
			4'd1:    u = '{2'd0, 2'd1, TS_CS, 1'b0};
			4'd2:    u = '{2'd1, 2'd0, TS_CS, 1'b0};
			4'd3:    u = '{2'd1, 2'd1, TS_SS, 1'b0};
			4'd4:    u = '{2'd0, 2'd2, TS_CC, 1'b1};
			4'd5:    u = '{2'd0, 2'd3, TS_CS, 1'b1};
			4'd6:    u = '{2'd1, 2'd2, TS_CS, 1'b1};
			4'd7:    u = '{2'd1, 2'd3, TS_SS, 1'b1};
			4'd8:    u = '{2'd2, 2'd0, TS_CC, 1'b1};
			4'd9:    u = '{2'd2, 2'd1, TS_CS, 1'b1};
			4'd10:   u = '{2'd3, 2'd0, TS_CS, 1'b1};
			4'd11:   u = '{2'd3, 2'd1, TS_SS, 1'b1};
			4'd12:   u = '{2'd2, 2'd2, TS_CC, 1'b0};
			4'd13:   u = '{2'd2, 2'd3, TS_CS, 1'b0};
			4'd14:   u = '{2'd3, 2'd2, TS_CS, 1'b0};
			4'd15:   u = '{2'd3, 2'd3, TS_SS, 1'b0};
			default: u = '{2'd0, 2'd0, TS_CC, 1'b0};
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/tsa_fifo.sv =====
// ----------------------------------------------------------------------------
// tsa_fifo
// Two-entry queue used between the front and the back and for results.
// ----------------------------------------------------------------------------
module tsa_fifo #(
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] wdata,
	output logic          full,
	input  logic          pop,
	output logic [DW-1:0] rdata,
	output logic          empty
);

	logic [DW-1:0] mem_q [2];
	logic          wp_q;
	logic          rp_q;
	logic [1:0]    cnt_q;
	logic          do_push;
	logic          do_pop;

	// Occupancy flags.
	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rp_q];

	// Pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wp_q <= ~wp_q;
			if (do_pop) rp_q <= ~rp_q;
			if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
			else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wp_q] <= wdata;
	end

endmodule

// ===== rtl/tsa_front.sv =====
// ----------------------------------------------------------------------------
// tsa_front
// Accepts items, and for a strut works out length, direction cosines, axial
// stiffness over length and the three element terms with one shared
// multiplier, a bit-serial square root and a bit-serial divider.
// ----------------------------------------------------------------------------
module tsa_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                busy,
	input  logic [1:0]                          kind,
	input  logic signed [31:0]                  first_x,
	input  logic signed [31:0]                  first_y,
	input  logic signed [31:0]                  second_x,
	input  logic signed [31:0]                  second_y,
	input  logic [tsa_pkg::DOF_W-1:0]           first_dof_x,
	input  logic [tsa_pkg::DOF_W-1:0]           first_dof_y,
	input  logic [tsa_pkg::DOF_W-1:0]           second_dof_x,
	input  logic [tsa_pkg::DOF_W-1:0]           second_dof_y,
	input  logic [30:0]                         axial_stiffness,
	input  logic [tsa_pkg::DOF_W-1:0]           read_row,
	input  logic [tsa_pkg::DOF_W-1:0]           read_col,
	output tsa_pkg::job_t                       job,
	output logic                                job_push,
	input  logic                                job_full
);

	localparam logic [3:0] F_IDLE  = 4'd0;
	localparam logic [3:0] F_SQA   = 4'd1;
	localparam logic [3:0] F_SQB   = 4'd2;
	localparam logic [3:0] F_SQS   = 4'd3;
	localparam logic [3:0] F_SQRT  = 4'd4;
	localparam logic [3:0] F_DIVLD = 4'd5;
	localparam logic [3:0] F_DIV   = 4'd6;
	localparam logic [3:0] F_MUL   = 4'd7;
	localparam logic [3:0] F_EMIT  = 4'd8;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

	logic [3:0]         state_q;
	logic [5:0]         cnt_q;
	logic [1:0]         dsel_q;
	tsa_pkg::job_t      job_q;
	logic [32:0]        ax_q;
	logic [32:0]        ay_q;
	logic               sh_q;
	logic [30:0]        ae_q;
	logic [63:0]        mul_p_q;
	logic [63:0]        acc_q;
	logic [34:0]        rem_q;
	logic [31:0]        root_q;
	logic [32:0]        len_q;
	logic [63:0]        dvd_q;
	logic [47:0]        quo_q;
	logic [30:0]        c_q;
	logic [30:0]        s_q;
	logic [47:0]        k_q;
	logic [30:0]        pcc_q;
	logic [30:0]        pcs_q;
	logic [30:0]        pss_q;
	logic [61:0]        hi_q;

	logic signed [32:0] dx;
	logic signed [32:0] dy;
	logic [32:0]        ax;
	logic [32:0]        ay;
	logic [31:0]        a_w;
	logic [31:0]        b_w;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic [34:0]        sq_trial;
	logic [34:0]        sq_t;
	logic               sq_ge;
	logic [31:0]        root_next;
	logic [63:0]        div_n;
	logic [33:0]        dv_trial;
	logic               dv_ge;
	logic [47:0]        quo_next;
	logic [30:0]        quo_clamp;
	logic [29:0]        cmb_r;
	logic [48:0]        cmb_low;
	logic [48:0]        cmb_sum;
	logic [47:0]        term_w;

	assign busy     = (state_q != F_IDLE);
	assign job      = job_q;
	assign job_push = (state_q == F_EMIT) && !job_full;

	// Coordinate differences and their magnitudes.
	assign dx = $signed({second_x[31], second_x}) - $signed({first_x[31], first_x});
	assign dy = $signed({second_y[31], second_y}) - $signed({first_y[31], first_y});
	assign ax = dx[32] ? 33'(-dx) : 33'(dx);
	assign ay = dy[32] ? 33'(-dy) : 33'(dy);

	// Magnitudes scaled down by one bit when they are large.
	assign a_w = sh_q ? ax_q[32:1] : ax_q[31:0];
	assign b_w = sh_q ? ay_q[32:1] : ay_q[31:0];

	// Operand selection for the shared multiplier.
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (state_q)
			F_SQA: begin
				mul_a = a_w;
				mul_b = a_w;
			end
			F_SQB: begin
				mul_a = b_w;
				mul_b = b_w;
			end
			F_MUL: begin
				case (cnt_q)
					6'd0: begin
						mul_a = {1'b0, c_q};
						mul_b = {1'b0, c_q};
					end
					6'd1: begin
						mul_a = {1'b0, c_q};
						mul_b = {1'b0, s_q};
					end
					6'd2: begin
						mul_a = {1'b0, s_q};
						mul_b = {1'b0, s_q};
					end
					6'd3: begin
						mul_a = {1'b0, k_q[47:17]};
						mul_b = {1'b0, pcc_q};
					end
					6'd4: begin
						mul_a = {15'd0, k_q[16:0]};
						mul_b = {1'b0, pcc_q};
					end
					6'd5: begin
						mul_a = {1'b0, k_q[47:17]};
						mul_b = {1'b0, pcs_q};
					end
					6'd6: begin
						mul_a = {15'd0, k_q[16:0]};
						mul_b = {1'b0, pcs_q};
					end
					6'd7: begin
						mul_a = {1'b0, k_q[47:17]};
						mul_b = {1'b0, pss_q};
					end
					6'd8: begin
						mul_a = {15'd0, k_q[16:0]};
						mul_b = {1'b0, pss_q};
					end
					default: begin
						mul_a = 32'd0;
						mul_b = 32'd0;
					end
				endcase
			end
			default: begin
				mul_a = 32'd0;
				mul_b = 32'd0;
			end
		endcase
	end

	// One square-root digit per cycle.
	assign sq_trial  = {rem_q[32:0], acc_q[63:62]};
	assign sq_t      = {1'b0, root_q, 2'b01};
	assign sq_ge     = (sq_trial >= sq_t);
	assign root_next = {root_q[30:0], sq_ge};

	// Dividend for the division in hand.
	always_comb begin
		case (dsel_q)
			2'd0:    div_n = {1'b0, ax_q, 30'd0};
			2'd1:    div_n = {1'b0, ay_q, 30'd0};
			default: div_n = {17'd0, ae_q, 16'd0};
		endcase
	end

	// One quotient bit per cycle.
	assign dv_trial  = {rem_q[32:0], dvd_q[63]};
	assign dv_ge     = (dv_trial >= {1'b0, len_q});
	assign quo_next  = {quo_q[46:0], dv_ge};
	assign quo_clamp = (quo_next > {17'd0, ONE_Q30}) ? ONE_Q30 : quo_next[30:0];

	// Joins the high and low partial products of k times a Q1.30 product.
	assign cmb_r   = {hi_q[12:0], 17'd0};
	assign cmb_low = {19'd0, cmb_r} + {1'b0, mul_p_q[47:0]};
	assign cmb_sum = hi_q[61:13] + {30'd0, cmb_low[48:30]};
	assign term_w  = cmb_sum[47:0];

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= 6'd0;
			dsel_q  <= 2'd0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (push) begin
						if (kind == tsa_pkg::KIND_ADD && (ax != 33'd0 || ay != 33'd0))
							state_q <= F_SQA;
						else
							state_q <= F_EMIT;
					end
				end
				F_SQA: state_q <= F_SQB;
				F_SQB: state_q <= F_SQS;
				F_SQS: begin
					cnt_q   <= 6'd0;
					state_q <= F_SQRT;
				end
				F_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						dsel_q  <= 2'd0;
						state_q <= F_DIVLD;
					end
				end
				F_DIVLD: begin
					cnt_q   <= 6'd0;
					state_q <= F_DIV;
				end
				F_DIV: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd47) begin
						if (dsel_q == 2'd2) begin
							cnt_q   <= 6'd0;
							state_q <= F_MUL;
						end else begin
							dsel_q  <= dsel_q + 2'd1;
							state_q <= F_DIVLD;
						end
					end
				end
				F_MUL: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd9) state_q <= F_EMIT;
				end
				F_EMIT: begin
					if (!job_full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		mul_p_q <= 64'(mul_a) * 64'(mul_b);
		case (state_q)
			F_IDLE: begin
				if (push) begin
					job_q.kind     <= kind;
					job_q.zero_len <= (ax == 33'd0) && (ay == 33'd0);
					job_q.cs_neg   <= dx[32] ^ dy[32];
					job_q.dof1     <= first_dof_x;
					job_q.dof2     <= first_dof_y;
					job_q.dof3     <= second_dof_x;
					job_q.dof4     <= second_dof_y;
					job_q.read_row <= read_row;
					job_q.read_col <= read_col;
					job_q.tcc      <= '0;
					job_q.tcs      <= '0;
					job_q.tss      <= '0;
					ax_q           <= ax;
					ay_q           <= ay;
					sh_q           <= ax[32] | ax[31] | ay[32] | ay[31];
					ae_q           <= axial_stiffness;
				end
			end
			F_SQB: acc_q <= mul_p_q;
			F_SQS: begin
				acc_q  <= acc_q + mul_p_q;
				rem_q  <= 35'd0;
				root_q <= 32'd0;
			end
			F_SQRT: begin
				rem_q  <= sq_ge ? (sq_trial - sq_t) : sq_trial;
				root_q <= root_next;
				acc_q  <= {acc_q[61:0], 2'b00};
				if (cnt_q == 6'd31)
					len_q <= sh_q ? {root_next, 1'b0} : {1'b0, root_next};
			end
			F_DIVLD: begin
				rem_q <= {19'd0, div_n[63:48]};
				dvd_q <= {div_n[47:0], 16'd0};
				quo_q <= 48'd0;
			end
			F_DIV: begin
				rem_q <= dv_ge ? {1'b0, dv_trial - {1'b0, len_q}} : {1'b0, dv_trial};
				dvd_q <= {dvd_q[62:0], 1'b0};
				quo_q <= quo_next;
				if (cnt_q == 6'd47) begin
					case (dsel_q)
						2'd0:    c_q <= quo_clamp;
						2'd1:    s_q <= quo_clamp;
						default: k_q <= quo_next;
					endcase
				end
			end
			F_MUL: begin
				case (cnt_q)
					6'd1:    pcc_q <= mul_p_q[60:30];
					6'd2:    pcs_q <= mul_p_q[60:30];
					6'd3:    pss_q <= mul_p_q[60:30];
					6'd4:    hi_q  <= mul_p_q[61:0];
					6'd5:    job_q.tcc <= term_w;
					6'd6:    hi_q  <= mul_p_q[61:0];
					6'd7:    job_q.tcs <= term_w;
					6'd8:    hi_q  <= mul_p_q[61:0];
					6'd9:    job_q.tss <= term_w;
					default: hi_q  <= hi_q;
				endcase
			end
			default: acc_q <= acc_q;
		endcase
	end

endmodule

// ===== rtl/tsa_back.sv =====
// ----------------------------------------------------------------------------
// tsa_back
// Holds the stiffness matrix memory and carries out classified items: the
// sixteen read-modify-write updates of a strut, entry reads and clears.
// ----------------------------------------------------------------------------
module tsa_back #(
	parameter int MAX_DOFS = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tsa_pkg::job_t                 job_in,
	input  logic                          job_empty,
	output logic                          job_pop,
	output logic                          init_busy,
	output logic [tsa_pkg::ENTRY_W-1:0]   res_value,
	output logic [1:0]                    res_status,
	output logic                          res_push,
	input  logic                          res_full
);

	localparam int DEPTH = MAX_DOFS * MAX_DOFS;
	localparam int AW    = $clog2(DEPTH);
	localparam int WW    = AW + 8;
	localparam logic [WW-1:0] MD_W  = WW'(MAX_DOFS);
	localparam logic [8:0]    MD_9  = 9'(MAX_DOFS);
	localparam logic [AW-1:0] LAST  = AW'(DEPTH - 1);

	localparam logic [2:0] B_CLR  = 3'd0;
	localparam logic [2:0] B_IDLE = 3'd1;
	localparam logic [2:0] B_URD  = 3'd2;
	localparam logic [2:0] B_UWR  = 3'd3;
	localparam logic [2:0] B_RDW  = 3'd4;
	localparam logic [2:0] B_RESP = 3'd5;

	logic [tsa_pkg::ENTRY_W-1:0] mem [DEPTH];
	logic [tsa_pkg::ENTRY_W-1:0] rdata_q;

	logic [2:0]                  state_q;
	logic                        clr_item_q;
	logic [AW-1:0]               clr_cnt_q;
	logic [3:0]                  upd_q;
	logic                        sat_q;
	tsa_pkg::job_t               job_q;
	logic [tsa_pkg::ENTRY_W-1:0] res_val_q;

	tsa_pkg::upd_t               u;
	logic [tsa_pkg::DOF_W-1:0]   row;
	logic [tsa_pkg::DOF_W-1:0]   col;
	logic [tsa_pkg::TERM_W-1:0]  mag;
	logic                        neg;
	logic                        upd_ok;
	logic [AW-1:0]               upd_addr;
	logic                        rd_ok;
	logic [AW-1:0]               rd_addr;
	logic signed [48:0]          term_s;
	logic signed [49:0]          sum;
	logic                        sat_hi;
	logic                        sat_lo;
	logic [tsa_pkg::ENTRY_W-1:0] new_val;
	logic                        start;
	logic                        mem_we;
	logic [AW-1:0]               mem_wa;
	logic [tsa_pkg::ENTRY_W-1:0] mem_wd;
	logic [AW-1:0]               mem_ra;

	// Checks a one-based row and column against the matrix size.
	function automatic logic in_range(input logic [tsa_pkg::DOF_W-1:0] r,
	                                  input logic [tsa_pkg::DOF_W-1:0] c);
		return (r != '0) && (c != '0) && ({2'b00, r} <= MD_9) && ({2'b00, c} <= MD_9);
	endfunction

	// Row-major address of a one-based entry.
	function automatic logic [AW-1:0] entry_addr(input logic [tsa_pkg::DOF_W-1:0] r,
	                                             input logic [tsa_pkg::DOF_W-1:0] c);
		logic [WW-1:0] w;
		w = WW'(r - 7'd1) * MD_W + WW'(c - 7'd1);
		return w[AW-1:0];
	endfunction

	// Current update of the strut schedule.
	assign u = tsa_pkg::upd_entry(upd_q);

	always_comb begin
		case (u.rsel)
			2'd0:    row = job_q.dof1;
			2'd1:    row = job_q.dof2;
			2'd2:    row = job_q.dof3;
			default: row = job_q.dof4;
		endcase
		case (u.csel)
			2'd0:    col = job_q.dof1;
			2'd1:    col = job_q.dof2;
			2'd2:    col = job_q.dof3;
			default: col = job_q.dof4;
		endcase
		case (u.tsel)
			tsa_pkg::TS_CC: mag = job_q.tcc;
			tsa_pkg::TS_CS: mag = job_q.tcs;
			default:        mag = job_q.tss;
		endcase
	end

	assign neg      = u.neg ^ ((u.tsel == tsa_pkg::TS_CS) && job_q.cs_neg);
	assign upd_ok   = in_range(row, col);
	assign upd_addr = entry_addr(row, col);
	assign rd_ok    = in_range(job_in.read_row, job_in.read_col);
	assign rd_addr  = entry_addr(job_in.read_row, job_in.read_col);

	// Saturating accumulation.
	assign term_s  = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	assign sum     = 50'($signed(rdata_q)) + 50'(term_s);
	assign sat_hi  = (sum > 50'(tsa_pkg::ENTRY_MAX));
	assign sat_lo  = (sum < 50'(tsa_pkg::ENTRY_MIN));
	assign new_val = sat_hi ? tsa_pkg::ENTRY_MAX :
	                 sat_lo ? tsa_pkg::ENTRY_MIN : sum[tsa_pkg::ENTRY_W-1:0];

	// Handshakes with the queues.
	assign start     = (state_q == B_IDLE) && !job_empty && !res_full;
	assign job_pop   = start;
	assign init_busy = (state_q == B_CLR) && !clr_item_q;
	assign res_push  = (state_q == B_RESP);
	assign res_value = res_val_q;

	always_comb begin
		res_status = tsa_pkg::STAT_OK;
		if (job_q.kind == tsa_pkg::KIND_ADD) begin
			if (job_q.zero_len) res_status = tsa_pkg::STAT_ZERO;
			else if (sat_q) res_status = tsa_pkg::STAT_SAT;
		end
	end

	// Memory port control.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = upd_addr;
		mem_wd = new_val;
		mem_ra = upd_addr;
		case (state_q)
			B_CLR: begin
				mem_we = 1'b1;
				mem_wa = clr_cnt_q;
				mem_wd = '0;
			end
			B_IDLE: mem_ra = rd_addr;
			B_UWR:  mem_we = 1'b1;
			default: mem_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rdata_q <= mem[mem_ra];
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= B_CLR;
			clr_item_q <= 1'b0;
			clr_cnt_q  <= '0;
			upd_q      <= 4'd0;
			sat_q      <= 1'b0;
		end else begin
			case (state_q)
				B_CLR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == LAST) state_q <= clr_item_q ? B_RESP : B_IDLE;
				end
				B_IDLE: begin
					if (start) begin
						upd_q <= 4'd0;
						sat_q <= 1'b0;
						case (job_in.kind)
							tsa_pkg::KIND_ADD:
								state_q <= job_in.zero_len ? B_RESP : B_URD;
							tsa_pkg::KIND_READ:
								state_q <= rd_ok ? B_RDW : B_RESP;
							tsa_pkg::KIND_CLEAR: begin
								clr_cnt_q  <= '0;
								clr_item_q <= 1'b1;
								state_q    <= B_CLR;
							end
							default: state_q <= B_RESP;
						endcase
					end
				end
				B_URD: begin
					if (upd_ok) begin
						state_q <= B_UWR;
					end else begin
						upd_q <= upd_q + 4'd1;
						if (upd_q == 4'd15) state_q <= B_RESP;
					end
				end
				B_UWR: begin
					sat_q <= sat_q | sat_hi | sat_lo;
					upd_q <= upd_q + 4'd1;
					state_q <= (upd_q == 4'd15) ? B_RESP : B_URD;
				end
				B_RDW:  state_q <= B_RESP;
				B_RESP: state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Item payload and read result.
	always_ff @(posedge clk) begin
		if (start) begin
			job_q     <= job_in;
			res_val_q <= '0;
		end else if (state_q == B_RDW) begin
			res_val_q <= rdata_q;
		end
	end

endmodule

// ===== rtl/truss_stiffness_assembler_core.sv =====
// ----------------------------------------------------------------------------
// truss_stiffness_assembler_core
// An add item takes 32 root steps and three 48-step divisions in the front, then
// a read and a write in the back for each in-range update of its sixteen. A read item
// reads one entry; a clear sweeps all MAX_DOFS squared entries of the matrix.
// The front takes a new item only once it is through with the last; the two queues
// let front and back overlap. After reset the matrix is swept to zero, during
// which full stays high.
// ----------------------------------------------------------------------------
module truss_stiffness_assembler_core #(
	parameter int MAX_DOFS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              push,
	output logic                              full,
	input  logic [1:0]                        kind,
	input  logic signed [31:0]                first_x,
	input  logic signed [31:0]                first_y,
	input  logic signed [31:0]                second_x,
	input  logic signed [31:0]                second_y,
	input  logic [6:0]                        first_dof_x,
	input  logic [6:0]                        first_dof_y,
	input  logic [6:0]                        second_dof_x,
	input  logic [6:0]                        second_dof_y,
	input  logic [30:0]                       axial_stiffness,
	input  logic [6:0]                        read_row,
	input  logic [6:0]                        read_col,
	output logic                              empty,
	input  logic                              pop,
	output logic signed [39:0]                entry_value,
	output logic [1:0]                        status
);

	localparam int JW = $bits(tsa_pkg::job_t);

	logic          front_busy;
	logic          init_busy;
	tsa_pkg::job_t front_job;
	logic          job_push;
	logic          job_full;
	logic [JW-1:0] job_vec;
	tsa_pkg::job_t back_job;
	logic          job_empty;
	logic          job_pop;
	logic [39:0]   res_value;
	logic [1:0]    res_status;
	logic          res_push;
	logic          res_full;
	logic [41:0]   res_out;

	// Input side of the queue interface.
	assign full = front_busy | init_busy;

	tsa_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push && !full),
		.busy            (front_busy),
		.kind            (kind),
		.first_x         (first_x),
		.first_y         (first_y),
		.second_x        (second_x),
		.second_y        (second_y),
		.first_dof_x     (first_dof_x),
		.first_dof_y     (first_dof_y),
		.second_dof_x    (second_dof_x),
		.second_dof_y    (second_dof_y),
		.axial_stiffness (axial_stiffness),
		.read_row        (read_row),
		.read_col        (read_col),
		.job             (front_job),
		.job_push        (job_push),
		.job_full        (job_full)
	);

	// Queue of classified items between front and back.
	tsa_fifo #(.DW(JW)) u_job_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.wdata  (front_job),
		.full   (job_full),
		.pop    (job_pop),
		.rdata  (job_vec),
		.empty  (job_empty)
	);

	assign back_job = tsa_pkg::job_t'(job_vec);

	tsa_back #(.MAX_DOFS(MAX_DOFS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_in     (back_job),
		.job_empty  (job_empty),
		.job_pop    (job_pop),
		.init_busy  (init_busy),
		.res_value  (res_value),
		.res_status (res_status),
		.res_push   (res_push),
		.res_full   (res_full)
	);

	// Result queue facing the consumer.
	tsa_fifo #(.DW(42)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  ({res_status, res_value}),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_out),
		.empty  (empty)
	);

	assign entry_value = $signed(res_out[39:0]);
	assign status      = res_out[41:40];

endmodule
